// ===== rtl/rhc_pkg.sv =====
package rhc_pkg;

  localparam int ChanW  = 8;
  localparam int OutW   = 15;
  localparam int NumW   = 23;
  localparam int QuoW   = 15;
  localparam int NCells = QuoW;

  localparam logic [NumW-1:0] PctFix = NumW'(25600);
  localparam logic [NumW-1:0] HueSec = NumW'(3840);
  localparam logic [NumW-1:0] OffG   = NumW'(7680);
  localparam logic [NumW-1:0] OffB   = NumW'(15360);
  localparam logic [NumW-1:0] OffW   = NumW'(23040);

  // one divider lane carried down the cell chain
  typedef struct packed {
    logic [NumW-1:0] rem;
    logic [ChanW-1:0] den;
    logic [QuoW-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic  valid;
    lane_t hue;
    lane_t sat;
    logic [OutW-1:0] bri;
  } token_t;

endpackage

// ===== rtl/rhc_div_cell.sv =====
module rhc_div_cell import rhc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   stall,
  input  token_t din,
  output token_t dout
);

  token_t nxt;

  // one restoring-divide step for both lanes: shift remainder, try subtract
  function automatic lane_t step(input lane_t l);
    logic [NumW:0] r2;
    logic [NumW:0] t;
    lane_t o;
    r2 = {l.rem, 1'b0};
    t  = r2 - {1'b0, l.den, {QuoW{1'b0}}};
    o = l;
    o.quo = {l.quo[QuoW-2:0], 1'b0};
    if (!t[NumW]) begin
      o.rem = t[NumW-1:0];
      o.quo[0] = 1'b1;
    end else begin
      o.rem = r2[NumW-1:0];
    end
    return o;
  endfunction

  always_comb begin
    nxt = din;
    nxt.hue = step(din.hue);
    nxt.sat = step(din.sat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (!stall) begin
      dout.valid <= nxt.valid;
    end
    if (!stall) begin
      dout.hue <= nxt.hue;
      dout.sat <= nxt.sat;
      dout.bri <= nxt.bri;
    end
  end

endmodule

// ===== rtl/rhc_front.sv =====
module rhc_front import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             stall,
  input  logic             valid,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  output token_t           dout
);

  logic [ChanW-1:0] mx, mn, d;
  logic [ChanW:0]   num;
  logic [NumW-1:0]  off, numx, hnum, snum, bprod;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    d = mx - mn;
    // num is a signed difference in two's complement
    if (mx == red) begin
      num = {1'b0, green} - {1'b0, blue};
      off = (green < blue) ? OffW : '0;
    end else if (mx == green) begin
      num = {1'b0, blue} - {1'b0, red};
      off = OffG;
    end else begin
      num = {1'b0, red} - {1'b0, green};
      off = OffB;
    end
    numx = {{(NumW-ChanW-1){num[ChanW]}}, num};
    // wraps modulo 2^NumW; the true sum is never negative and fits
    hnum = off * NumW'(d) + HueSec * numx;
    snum = PctFix * NumW'(d);
    bprod = PctFix * NumW'(mx);
  end

  // brightness: divide by 255 with reciprocal 257/65536 and correction
  logic [31:0] q0;
  logic [NumW-1:0] r0;
  logic [OutW-1:0] bq;
  always_comb begin
    q0 = ({24'd0, mx} * 32'd6579200) >> 16;
    r0 = bprod - NumW'(q0[15:0]) * NumW'(255);
    bq = OutW'(q0[15:0]);
    if (r0 >= NumW'(255)) bq = bq + OutW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (!stall) begin
      dout.valid <= valid;
    end
    if (!stall) begin
      dout.hue.rem <= (d == 0) ? '0 : hnum;
      dout.hue.den <= (d == 0) ? ChanW'(1) : d;
      dout.hue.quo <= '0;
      dout.sat.rem <= (mx == 0) ? '0 : snum;
      dout.sat.den <= (mx == 0) ? ChanW'(1) : mx;
      dout.sat.quo <= '0;
      dout.bri     <= bq;
    end
  end

endmodule

// ===== rtl/rgb_to_hsv_converter_top.sv =====
// RGB to HSV pixel converter.
// Input channel: valid/stall with red, green, blue bytes; a transaction is
// taken when valid is high and stall is low.
// Output channel: valid/stall with hue (1/64 degree), saturation and
// brightness (percent times 256), all truncated.
// Pipeline: one front stage (min/max, sector, numerators, brightness by
// reciprocal) and a chain of 15 divider cells, one quotient bit per cell;
// the last cell drives the outputs.
// Throughput: one pixel per clock unless held; every stage moves together.
// The whole pipeline holds while a stalled output has a valid result; in_stall then
// follows out_stall, so a stalled result and all items behind it stay put.
// Reset clears all valid flags; payload registers are not reset.
module rgb_to_hsv_converter_top import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [OutW-1:0]  hue,
  output logic [OutW-1:0]  saturation,
  output logic [OutW-1:0]  brightness
);

  token_t chain [NCells+1];
  logic   hold;

  // only stall when the final result is waiting and can't leave
  assign hold     = out_stall && chain[NCells].valid;
  assign in_stall = hold;

  rhc_front u_front (
    .clk(clk), .rst(rst), .stall(hold), .valid(in_valid),
    .red(red), .green(green), .blue(blue), .dout(chain[0])
  );

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk(clk), .rst(rst), .stall(hold), .din(chain[i]), .dout(chain[i+1])
    );
  end

  assign out_valid  = chain[NCells].valid;
  assign hue        = chain[NCells].hue.quo;
  assign saturation = chain[NCells].sat.quo;
  assign brightness = chain[NCells].bri;

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(hue) && $stable(saturation))
    else $error("result changed under stall");
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> hue < OutW'(23040))
    else $error("hue out of range");
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> saturation <= OutW'(25600) && brightness <= OutW'(25600))
    else $error("percent out of range");

endmodule

// ===== tb/hsv_checker.sv =====
`timescale 1ns / 100ps

module hsv_checker import rhc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [OutW-1:0]  hue,
  input  logic [OutW-1:0]  saturation,
  input  logic [OutW-1:0]  brightness,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [OutW-1:0] hue;
    logic [OutW-1:0] sat;
    logic [OutW-1:0] bri;
  } hsv_t;

  hsv_t hsv_q[$];

  function automatic hsv_t predict_hsv(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                       logic [ChanW-1:0] b);
    int mx, mn, d, num, off;
    hsv_t res;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    res.bri = OutW'((mx * 25600) / 255);
    res.sat = (mx != 0) ? OutW'((d * 25600) / mx) : '0;
    res.hue = '0;
    if (d != 0) begin
      // sector pick order on ties: red, green, blue
      if (mx == r) begin
        num = int'(g) - int'(b);
        off = (g < b) ? 360 : 0;
      end else if (mx == g) begin
        num = int'(b) - int'(r);
        off = 120;
      end else begin
        num = int'(r) - int'(g);
        off = 240;
      end
      res.hue = OutW'((off * 64 * d + 3840 * num) / d);
    end
    return res;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $time);
    fail_count++;
  endtask

  assign pending = hsv_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    hsv_t want;
    if (!rst) begin
      if (in_valid && !in_stall) hsv_q.push_back(predict_hsv(red, green, blue));
      if (out_valid && !out_stall) begin
        if (hsv_q.size() == 0) begin
          report_mismatch("result count", 1, 0);
        end else begin
          want = hsv_q.pop_front();
          if (hue != want.hue) report_mismatch("hue", hue, want.hue);
          if (saturation != want.sat) report_mismatch("saturation", saturation, want.sat);
          if (brightness != want.bri) report_mismatch("brightness", brightness, want.bri);
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rhc_pkg::*;

  localparam int RandPixels = 2000;
  localparam int CycleLimit = 200000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [ChanW-1:0] red = '0, green = '0, blue = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [OutW-1:0]  hue, saturation, brightness;
  int               fail_count, pending;
  int               cycles = 0;
  bit               calm = 1'b0;
  bit               hold_off = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  rgb_to_hsv_converter_top uut (.*);

  hsv_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off to fill the pipeline
  initial begin
    int n;
    @(negedge rst);
    repeat (5) @(posedge clk);
    hold_off = 1'b1;
    out_stall <= 1'b1;
    repeat (60) @(posedge clk);
    hold_off = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        n = int'($urandom_range(1, 7));
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                            logic [ChanW-1:0] b);
    int n;
    if (!calm && !hold_off && $urandom_range(0, 4) == 0) begin
      n = int'($urandom_range(1, 7));
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    red <= r;
    green <= g;
    blue <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    logic [ChanW-1:0] r, g, b;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // black, white, grey, primaries, secondaries, ties, wrap sector
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd1);
    send_pixel(8'd0, 8'd1, 8'd1);
    send_pixel(8'd200, 8'd10, 8'd200);
    send_pixel(8'd10, 8'd200, 8'd200);
    send_pixel(8'd255, 8'd254, 8'd253);
    send_pixel(8'd170, 8'd85, 8'd0);
    for (int i = 0; i < RandPixels; i++) begin
      if (i > RandPixels * 9 / 10) calm = 1'b1;
      r = ChanW'($urandom); g = ChanW'($urandom); b = ChanW'($urandom);
      // some ties and near-grey pixels
      case ($urandom_range(0, 7))
        0: g = r;
        1: b = g;
        2: begin g = r; b = r; end
        3: b = r + ChanW'($urandom_range(0, 2));
        default: ;
      endcase
      send_pixel(r, g, b);
    end
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
